/* hdl/pcp_pkg.sv */
// Shared types, constants and helper functions for the player control panel.
`default_nettype none

package pcp_pkg;

	// Width of every tick counter; counters stop at the all-ones value.
	localparam int unsigned TimerWidth = 14;
	localparam logic [TimerWidth-1:0] TimerMax = {TimerWidth{1'b1}};

	// Highest track number the player supports, and the number of equaliser presets.
	localparam int unsigned TrackLimit = 255;
	localparam int unsigned EqPresetCount = 6;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_DEBOUNCE_TICKS   = 3'd0,
		REG_LONG_PRESS_TICKS = 3'd1,
		REG_VOLUME_MIN       = 3'd2,
		REG_VOLUME_MAX       = 3'd3,
		REG_VOLUME_START     = 3'd4,
		REG_TOTAL_TRACKS     = 3'd5
	} cfg_reg_t;

	// Volume loaded at reset.
	localparam logic [4:0] VolumeReset = 5'd15;

	typedef logic [TimerWidth-1:0] timer_t;

	// Saturating increment of a tick counter.
	function automatic timer_t sat_inc(input timer_t v);
		timer_t r;
		r = (v == TimerMax) ? TimerMax : v + timer_t'(1);
		return r;
	endfunction

endpackage

`default_nettype wire

/* hdl/pcp_debounce.sv */
// Debouncer for one active-low push button, with a change timer per button.
`default_nettype none

module pcp_debounce (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       en,
	input  wire logic       level,
	input  wire logic [9:0] debounce_ticks,
	output logic            fire
);

	logic            raw_q;
	logic            stable_q;
	pcp_pkg::timer_t timer_q;
	pcp_pkg::timer_t timer_n;

	// The timer restarts whenever the raw level moves, otherwise it counts up.
	always_comb begin
		if (level != raw_q) begin
			timer_n = '0;
		end else begin
			timer_n = pcp_pkg::sat_inc(timer_q);
		end
	end

	// The stable level follows once the raw level has held long enough.
	assign fire = (timer_n > {4'd0, debounce_ticks}) && (level != stable_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q    <= 1'b1;
			stable_q <= 1'b1;
			timer_q  <= '0;
		end else if (en) begin
			raw_q   <= level;
			timer_q <= timer_n;
			if (fire) begin
				stable_q <= level;
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/player_control_panel.sv */
// Top level of the player control panel: input register, tick logic and result register.
//
//  Channel  Signals                       Direction  Moves
//  in       in_valid / in_stall           to block   one item per millisecond tick
//  out      out_valid / out_stall         from block one result item per tick
//  cfg      cfg_valid / cfg_ready         to block   one register write
//
// An item is captured in the input register, then processed once the result register
// is free, against the player state, which loads together with the result register.
// One item is accepted every clock while in_stall is low.
// in_stall rises only while an item waits in the input register and the result
// register is full and stalled. cfg_ready is always high.
// Reset clears the player state: track 1, playing, volume 15, preset 0.
`default_nettype none

module player_control_panel (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// Input items
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic signed [7:0] enc_delta,
	input  wire logic              enc_switch_level,
	input  wire logic              next_level,
	input  wire logic              prev_level,
	input  wire logic              track_finished,
	// Result items
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [7:0]             track_now,
	output logic [4:0]             volume_now,
	output logic                   playing_now,
	output logic [2:0]             eq_now,
	output logic                   start_track_cmd,
	output logic                   volume_cmd,
	output logic                   eq_cmd,
	output logic                   pause_cmd,
	output logic                   resume_cmd,
	// Configuration writes
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [13:0]       cfg_data
);

	// Configuration registers
	logic [9:0]      debounce_ticks_q;
	pcp_pkg::timer_t long_press_ticks_q;
	logic [4:0]      volume_min_q;
	logic [4:0]      volume_max_q;
	logic [7:0]      total_tracks_q;

	// Input register
	logic              valid_s1;
	logic signed [7:0] delta_s1;
	logic              sw_s1;
	logic              next_s1;
	logic              prev_s1;
	logic              fin_s1;

	// Player state, shown directly as the result payload
	logic [7:0]      track_q;
	logic [4:0]      volume_q;
	logic            playing_q;
	logic [2:0]      eq_q;
	pcp_pkg::timer_t hold_q;
	logic            armed_q;
	logic            out_valid_q;
	logic            start_cmd_q;
	logic            vol_cmd_q;
	logic            eq_cmd_q;
	logic            pause_cmd_q;
	logic            resume_cmd_q;

	// Next-state values
	logic            advance;
	logic            sw_fire;
	logic            next_fire;
	logic            prev_fire;
	logic [7:0]      count;
	logic [7:0]      track_a;
	logic [7:0]      track_b;
	logic [7:0]      track_n;
	logic signed [9:0] vol_sum;
	logic [4:0]      volume_n;
	logic            vol_cmd_n;
	pcp_pkg::timer_t hold_n;
	logic            armed_n;
	logic            playing_n;
	logic [2:0]      eq_n;
	logic            eq_cmd_n;
	logic            pause_n;
	logic            resume_n;
	logic            start_n;

	// Pipeline control: the held item moves on when the result register is free.
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign cfg_ready = 1'b1;

	// Configuration write decode; start volume writes are ignored, reset loads VolumeReset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ticks_q   <= 10'd50;
			long_press_ticks_q <= pcp_pkg::timer_t'(1000);
			volume_min_q       <= 5'd0;
			volume_max_q       <= 5'd30;
			total_tracks_q     <= 8'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (pcp_pkg::cfg_reg_t'(cfg_index))
				pcp_pkg::REG_DEBOUNCE_TICKS:   debounce_ticks_q   <= cfg_data[9:0];
				pcp_pkg::REG_LONG_PRESS_TICKS: long_press_ticks_q <= cfg_data;
				pcp_pkg::REG_VOLUME_MIN:       volume_min_q       <= cfg_data[4:0];
				pcp_pkg::REG_VOLUME_MAX:       volume_max_q       <= cfg_data[4:0];
				pcp_pkg::REG_VOLUME_START:     ;
				pcp_pkg::REG_TOTAL_TRACKS:     total_tracks_q     <= cfg_data[7:0];
				default:                       ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			delta_s1 <= enc_delta;
			sw_s1    <= enc_switch_level;
			next_s1  <= next_level;
			prev_s1  <= prev_level;
			fin_s1   <= track_finished;
		end
	end

	// Button debouncers
	pcp_debounce u_sw_deb (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (advance),
		.level          (sw_s1),
		.debounce_ticks (debounce_ticks_q),
		.fire           (sw_fire)
	);

	pcp_debounce u_next_deb (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (advance),
		.level          (next_s1),
		.debounce_ticks (debounce_ticks_q),
		.fire           (next_fire)
	);

	pcp_debounce u_prev_deb (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (advance),
		.level          (prev_s1),
		.debounce_ticks (debounce_ticks_q),
		.fire           (prev_fire)
	);

	// Volume: add the step count, clamp to the maximum and then to the minimum.
	always_comb begin
		vol_sum  = $signed({5'd0, volume_q}) + 10'(delta_s1);
		volume_n = volume_q;
		vol_cmd_n = (delta_s1 != 8'sd0);
		if (vol_cmd_n) begin
			if (vol_sum > $signed({5'd0, volume_max_q})) begin
				volume_n = volume_max_q;
			end else begin
				volume_n = vol_sum[4:0];
			end
			if (vol_sum < $signed({5'd0, volume_min_q}) || volume_n < volume_min_q) begin
				volume_n = volume_min_q;
			end
		end
	end

	// Encoder switch: short press toggles play, long hold steps the equaliser.
	always_comb begin
		hold_n    = armed_q ? pcp_pkg::sat_inc(hold_q) : hold_q;
		armed_n   = armed_q;
		playing_n = playing_q;
		pause_n   = 1'b0;
		resume_n  = 1'b0;
		eq_n      = eq_q;
		eq_cmd_n  = 1'b0;
		if (sw_fire) begin
			if (!sw_s1) begin
				hold_n  = '0;
				armed_n = 1'b1;
			end else begin
				if (armed_q) begin
					playing_n = !playing_q;
					pause_n   = playing_q;
					resume_n  = !playing_q;
				end
				armed_n = 1'b0;
			end
		end
		if (armed_n && !sw_s1 && hold_n >= long_press_ticks_q) begin
			armed_n  = 1'b0;
			eq_cmd_n = 1'b1;
			if ({1'b0, eq_q} + 4'd1 >= 4'(pcp_pkg::EqPresetCount)) begin
				eq_n = 3'd0;
			end else begin
				eq_n = eq_q + 3'd1;
			end
		end
	end

	// Track stepping: next, then previous, then track finished, each with wrap.
	always_comb begin
		count = (total_tracks_q == 8'd0) ? 8'd1 : total_tracks_q;
		if (16'(count) > 16'(pcp_pkg::TrackLimit)) begin
			count = 8'(pcp_pkg::TrackLimit);
		end
		track_a = track_q;
		if (next_fire && !next_s1) begin
			track_a = (track_q >= count) ? 8'd1 : track_q + 8'd1;
		end
		track_b = track_a;
		if (prev_fire && !prev_s1) begin
			track_b = (track_a <= 8'd1 || track_a > count) ? count : track_a - 8'd1;
		end
		track_n = track_b;
		if (fin_s1) begin
			track_n = (track_b >= count) ? 8'd1 : track_b + 8'd1;
		end
		start_n = (next_fire && !next_s1) || (prev_fire && !prev_s1) || fin_s1;
	end

	// Player state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			track_q      <= 8'd1;
			volume_q     <= pcp_pkg::VolumeReset;
			playing_q    <= 1'b1;
			eq_q         <= 3'd0;
			hold_q       <= '0;
			armed_q      <= 1'b0;
			start_cmd_q  <= 1'b0;
			vol_cmd_q    <= 1'b0;
			eq_cmd_q     <= 1'b0;
			pause_cmd_q  <= 1'b0;
			resume_cmd_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q  <= 1'b1;
				track_q      <= track_n;
				volume_q     <= volume_n;
				playing_q    <= playing_n || start_n;
				eq_q         <= eq_n;
				hold_q       <= hold_n;
				armed_q      <= armed_n;
				start_cmd_q  <= start_n;
				vol_cmd_q    <= vol_cmd_n;
				eq_cmd_q     <= eq_cmd_n;
				pause_cmd_q  <= pause_n;
				resume_cmd_q <= resume_n;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign track_now       = track_q;
	assign volume_now      = volume_q;
	assign playing_now     = playing_q;
	assign eq_now          = eq_q;
	assign start_track_cmd = start_cmd_q;
	assign volume_cmd      = vol_cmd_q;
	assign eq_cmd          = eq_cmd_q;
	assign pause_cmd       = pause_cmd_q;
	assign resume_cmd      = resume_cmd_q;

	// The held item never waits while the result register is empty.
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> !in_stall)
		else $error("input stalled with an empty result register");

	// A short press either pauses or resumes, never both.
	a_pause_resume_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(pause_cmd_q && resume_cmd_q))
		else $error("pause and resume in the same item");

	// A pause shows the player stopped unless a track was started in the same tick.
	a_pause_state: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && pause_cmd_q && !start_cmd_q) |-> !playing_q)
		else $error("pause reported while still playing");

	// The equaliser index stays below the preset count and the track is never zero.
	a_state_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (({1'b0, eq_q} < 4'(pcp_pkg::EqPresetCount)) && (track_q != 8'd0)))
		else $error("player state out of range");

	// Player state only moves when an item is processed.
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(advance) |-> ($stable(track_q) && $stable(eq_q) && $stable(volume_q)))
		else $error("player state changed without an item");

endmodule

`default_nettype wire

/* test/pcp_checker.sv */
`timescale 1ns / 1ps
// Checker for the player control panel: tracks register writes, predicts every tick and compares.
module pcp_checker (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_stall,
	input  wire logic signed [7:0] enc_delta,
	input  wire logic              enc_switch_level,
	input  wire logic              next_level,
	input  wire logic              prev_level,
	input  wire logic              track_finished,
	input  wire logic              out_valid,
	input  wire logic              out_stall,
	input  wire logic [7:0]        track_now,
	input  wire logic [4:0]        volume_now,
	input  wire logic              playing_now,
	input  wire logic [2:0]        eq_now,
	input  wire logic              start_track_cmd,
	input  wire logic              volume_cmd,
	input  wire logic              eq_cmd,
	input  wire logic              pause_cmd,
	input  wire logic              resume_cmd,
	input  wire logic              cfg_valid,
	input  wire logic              cfg_ready,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [13:0]       cfg_data,
	output int                     mismatches,
	output int                     awaiting,
	output int                     checked
);

	typedef struct packed {
		logic            raw;
		logic            stable;
		pcp_pkg::timer_t ticks;
	} button_t;

	typedef struct packed {
		logic [7:0] track;
		logic [4:0] volume;
		logic       playing;
		logic [2:0] eq;
		logic       start_track;
		logic       volume_chg;
		logic       eq_chg;
		logic       paused;
		logic       resumed;
	} panel_t;

	// Register copies.
	logic [9:0]  cfg_debounce;
	logic [13:0] cfg_long_press;
	logic [4:0]  cfg_vol_min;
	logic [4:0]  cfg_vol_max;
	logic [7:0]  cfg_tracks;

	// Predicted panel state.
	button_t         sw_btn, next_btn, prev_btn;
	pcp_pkg::timer_t hold_ticks;
	logic            long_armed;
	logic            is_playing;
	logic [7:0]      cur_track;
	logic [4:0]      cur_volume;
	logic [2:0]      eq_idx;

	panel_t pending_panels[$];
	int     mismatch_count;
	int     panels_checked;

	// One tick of a debouncer: the stable level follows the raw level once it has held
	// for more than the debounce time.
	function automatic button_t debounce_step(button_t b, logic lvl);
		button_t n;
		n = b;
		if (lvl != b.raw) begin
			n.raw = lvl;
			n.ticks = '0;
		end else if (b.ticks != pcp_pkg::TimerMax) begin
			n.ticks = b.ticks + pcp_pkg::timer_t'(1);
		end
		if (n.ticks > pcp_pkg::timer_t'(cfg_debounce) && lvl != n.stable)
			n.stable = lvl;
		return n;
	endfunction

	// Track count in force: zero counts as one, and the count never exceeds the limit.
	function automatic logic [7:0] tracks_in_use();
		logic [7:0] n;
		n = (cfg_tracks == 8'd0) ? 8'd1 : cfg_tracks;
		if (int'(n) > int'(pcp_pkg::TrackLimit))
			n = 8'(pcp_pkg::TrackLimit);
		return n;
	endfunction

	function automatic void advance_track();
		cur_track = (cur_track >= tracks_in_use()) ? 8'd1 : cur_track + 8'd1;
		is_playing = 1'b1;
	endfunction

	// Applies one tick to the predicted state and returns the panel it should report.
	function automatic panel_t panel_after_tick(logic signed [7:0] delta, logic sw, logic nx,
			logic pv, logic fin);
		panel_t     r;
		int         vol;
		logic       prior;
		logic [7:0] n;
		r = '0;

		// Encoder rotation: upper bound first, lower bound last.
		if (delta != 8'sd0) begin
			vol = int'(cur_volume) + int'(delta);
			if (vol > int'(cfg_vol_max))
				vol = int'(cfg_vol_max);
			if (vol < int'(cfg_vol_min))
				vol = int'(cfg_vol_min);
			cur_volume = 5'(vol);
			r.volume_chg = 1'b1;
		end

		// Encoder switch: a short press toggles playback, a long one steps the preset.
		if (long_armed && hold_ticks != pcp_pkg::TimerMax)
			hold_ticks = hold_ticks + pcp_pkg::timer_t'(1);
		prior = sw_btn.stable;
		sw_btn = debounce_step(sw_btn, sw);
		if (sw_btn.stable != prior) begin
			if (!sw) begin
				hold_ticks = '0;
				long_armed = 1'b1;
			end else begin
				if (long_armed) begin
					if (is_playing) begin
						is_playing = 1'b0;
						r.paused = 1'b1;
					end else begin
						is_playing = 1'b1;
						r.resumed = 1'b1;
					end
				end
				long_armed = 1'b0;
			end
		end
		if (long_armed && !sw && hold_ticks >= cfg_long_press) begin
			long_armed = 1'b0;
			eq_idx = (int'(eq_idx) + 1 >= int'(pcp_pkg::EqPresetCount)) ? 3'd0 : eq_idx + 3'd1;
			r.eq_chg = 1'b1;
		end

		// Track stepping: next, then previous, then the end of the track.
		prior = next_btn.stable;
		next_btn = debounce_step(next_btn, nx);
		if (next_btn.stable != prior && !nx) begin
			advance_track();
			r.start_track = 1'b1;
		end
		prior = prev_btn.stable;
		prev_btn = debounce_step(prev_btn, pv);
		if (prev_btn.stable != prior && !pv) begin
			n = tracks_in_use();
			cur_track = (cur_track <= 8'd1 || cur_track > n) ? n : cur_track - 8'd1;
			is_playing = 1'b1;
			r.start_track = 1'b1;
		end
		if (fin) begin
			advance_track();
			r.start_track = 1'b1;
		end

		r.track = cur_track;
		r.volume = cur_volume;
		r.playing = is_playing;
		r.eq = eq_idx;
		return r;
	endfunction

	// Four-state compare, so an unknown output never passes for a zero.
	function automatic int field_differs(string field, logic [7:0] want_v, logic [7:0] got_v);
		if (want_v === got_v)
			return 0;
		$error("%s: expected %0d, got %0d", field, want_v, got_v);
		return 1;
	endfunction

	// Register writes, then result comparison, then prediction of the newly accepted item.
	always @(posedge clk or negedge arst_n) begin
		panel_t want;
		int     bad;
		if (!arst_n) begin
			cfg_debounce = 10'd50;
			cfg_long_press = 14'd1000;
			cfg_vol_min = 5'd0;
			cfg_vol_max = 5'd30;
			cfg_tracks = 8'd1;
			sw_btn = '{raw: 1'b1, stable: 1'b1, ticks: '0};
			next_btn = sw_btn;
			prev_btn = sw_btn;
			hold_ticks = '0;
			long_armed = 1'b0;
			is_playing = 1'b1;
			cur_track = 8'd1;
			cur_volume = pcp_pkg::VolumeReset;
			eq_idx = 3'd0;
			pending_panels.delete();
			mismatch_count = 0;
			panels_checked = 0;
			mismatches <= 0;
			awaiting <= 0;
			checked <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					pcp_pkg::REG_DEBOUNCE_TICKS:   cfg_debounce = cfg_data[9:0];
					pcp_pkg::REG_LONG_PRESS_TICKS: cfg_long_press = cfg_data;
					pcp_pkg::REG_VOLUME_MIN:       cfg_vol_min = cfg_data[4:0];
					pcp_pkg::REG_VOLUME_MAX:       cfg_vol_max = cfg_data[4:0];
					// The start volume register is not stored by the panel, and the run has just one reset.
					pcp_pkg::REG_VOLUME_START:     ;
					pcp_pkg::REG_TOTAL_TRACKS:     cfg_tracks = cfg_data[7:0];
					default: ;
				endcase
			end

			if (out_valid && !out_stall) begin
				if (pending_panels.size() == 0) begin
					$error("result item with no tick waiting for it");
					mismatch_count++;
				end else begin
					want = pending_panels.pop_front();
					bad = 0;
					bad += field_differs("track_now", want.track, track_now);
					bad += field_differs("volume_now", want.volume, volume_now);
					bad += field_differs("playing_now", want.playing, playing_now);
					bad += field_differs("eq_now", want.eq, eq_now);
					bad += field_differs("start_track_cmd", want.start_track, start_track_cmd);
					bad += field_differs("volume_cmd", want.volume_chg, volume_cmd);
					bad += field_differs("eq_cmd", want.eq_chg, eq_cmd);
					bad += field_differs("pause_cmd", want.paused, pause_cmd);
					bad += field_differs("resume_cmd", want.resumed, resume_cmd);
					mismatch_count += bad;
					panels_checked++;
				end
			end

			if (in_valid && !in_stall)
				pending_panels.push_back(panel_after_tick(enc_delta, enc_switch_level,
					next_level, prev_level, track_finished));

			mismatches <= mismatch_count;
			awaiting <= pending_panels.size();
			checked <= panels_checked;
		end
	end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Testbench top for the player control panel: clock, reset, tick stimulus, stalls and verdict.
module tb_top;

	localparam int HalfPeriod = 4;
	localparam int ResetCycles = 7;
	localparam int HoldOffCycles = 300;
	localparam int QuietLimit = 3000;
	localparam int SettleCycles = 4;
	localparam int TailCycles = 8;
	localparam logic [2:0] RegSpare = 3'd7;
	localparam int BtnSwitch = 0;
	localparam int BtnNext = 1;
	localparam int BtnPrev = 2;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic              in_valid = 1'b0;
	logic signed [7:0] enc_delta = '0;
	logic              enc_switch_level = 1'b1;
	logic              next_level = 1'b1;
	logic              prev_level = 1'b1;
	logic              track_finished = 1'b0;
	logic              out_stall = 1'b0;
	logic              cfg_valid = 1'b0;
	logic [2:0]        cfg_index = '0;
	logic [13:0]       cfg_data = '0;

	logic       in_stall;
	logic       out_valid;
	logic [7:0] track_now;
	logic [4:0] volume_now;
	logic       playing_now;
	logic [2:0] eq_now;
	logic       start_track_cmd;
	logic       volume_cmd;
	logic       eq_cmd;
	logic       pause_cmd;
	logic       resume_cmd;
	logic       cfg_ready;

	int mismatches;
	int awaiting;
	int checked;

	// Stimulus shaping: current debounce and long-press settings, button runs and idling mode.
	logic [9:0]  deb_now = 10'd50;
	logic [13:0] lp_now = 14'd1000;
	logic [2:0]  level = 3'b111;
	int          run_left[3];
	bit          calm = 1'b0;
	bit          hold_off_req = 1'b0;
	int          ticks_sent = 0;
	int          settings_used = 0;
	int          quiet_cycles = 0;

	always begin
		#HalfPeriod clk = 1'b1;
		#HalfPeriod clk = 1'b0;
	end

	player_control_panel dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.enc_delta        (enc_delta),
		.enc_switch_level (enc_switch_level),
		.next_level       (next_level),
		.prev_level       (prev_level),
		.track_finished   (track_finished),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.track_now        (track_now),
		.volume_now       (volume_now),
		.playing_now      (playing_now),
		.eq_now           (eq_now),
		.start_track_cmd  (start_track_cmd),
		.volume_cmd       (volume_cmd),
		.eq_cmd           (eq_cmd),
		.pause_cmd        (pause_cmd),
		.resume_cmd       (resume_cmd),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	pcp_checker u_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.enc_delta        (enc_delta),
		.enc_switch_level (enc_switch_level),
		.next_level       (next_level),
		.prev_level       (prev_level),
		.track_finished   (track_finished),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.track_now        (track_now),
		.volume_now       (volume_now),
		.playing_now      (playing_now),
		.eq_now           (eq_now),
		.start_track_cmd  (start_track_cmd),
		.volume_cmd       (volume_cmd),
		.eq_cmd           (eq_cmd),
		.pause_cmd        (pause_cmd),
		.resume_cmd       (resume_cmd),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.mismatches       (mismatches),
		.awaiting         (awaiting),
		.checked          (checked)
	);

	// Watchdog: the run is stuck if nothing moves on any channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QuietLimit) begin
			$display("tb_top: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Result side: random stall runs, mostly short, plus one long hold-off on request.
	initial begin
		int len;
		int r;
		bit hold_off_done;
		hold_off_done = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_off_req && !hold_off_done) begin
				hold_off_done = 1'b1;
				len = HoldOffCycles;
				out_stall <= 1'b1;
			end else if (calm) begin
				len = 1;
				out_stall <= 1'b0;
			end else begin
				r = $urandom_range(99);
				if (r < 55) begin
					len = $urandom_range(1, 8);
					out_stall <= 1'b0;
				end else if (r < 93) begin
					len = $urandom_range(1, 3);
					out_stall <= 1'b1;
				end else begin
					len = $urandom_range(10, 40);
					out_stall <= 1'b1;
				end
			end
			repeat (len) @(posedge clk);
		end
	end

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Length of the next run of one button level: mostly long enough to settle, some bounces.
	function automatic int pick_run(bit is_switch, logic released);
		int settle;
		int r;
		settle = int'(deb_now) + 2;
		r = $urandom_range(99);
		if (r < 15)
			return $urandom_range(1, settle - 1);
		if (is_switch && !released)
			return settle + $urandom_range(0, (int'(lp_now) < 56) ? int'(lp_now) + 4 : 60);
		return settle + $urandom_range(0, 8);
	endfunction

	// Offers one tick item after an optional gap and waits until it is taken.
	task automatic send_tick(logic signed [7:0] delta, logic sw, logic nx, logic pv, logic fin);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		enc_delta <= delta;
		enc_switch_level <= sw;
		next_level <= nx;
		prev_level <= pv;
		track_finished <= fin;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		ticks_sent++;
	endtask

	// Stops offering items until every expected result item has come back.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaiting != 0)
			@(posedge clk);
	endtask

	task automatic cfg_write(logic [2:0] idx, logic [13:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	// Writes every register once the panel is idle.
	task automatic configure(logic [13:0] deb, logic [13:0] lp, logic [13:0] vmin,
			logic [13:0] vmax, logic [13:0] vstart, logic [13:0] tracks, bit with_spare);
		drain();
		repeat (SettleCycles) @(posedge clk);
		cfg_write(pcp_pkg::REG_DEBOUNCE_TICKS, deb);
		cfg_write(pcp_pkg::REG_LONG_PRESS_TICKS, lp);
		cfg_write(pcp_pkg::REG_VOLUME_MIN, vmin);
		cfg_write(pcp_pkg::REG_VOLUME_MAX, vmax);
		cfg_write(pcp_pkg::REG_VOLUME_START, vstart);
		cfg_write(pcp_pkg::REG_TOTAL_TRACKS, tracks);
		if (with_spare)
			cfg_write(RegSpare, 14'h3FFF);
		cfg_valid <= 1'b0;
		deb_now = deb[9:0];
		lp_now = lp;
		settings_used++;
	endtask

	// One random tick: button levels follow their runs, with occasional noise.
	task automatic random_tick();
		logic [2:0]        lv;
		logic signed [7:0] delta;
		int                r;
		for (int b = 0; b < 3; b++) begin
			if (run_left[b] == 0) begin
				level[b] = ~level[b];
				run_left[b] = pick_run(b == BtnSwitch, level[b]);
			end
			run_left[b]--;
		end
		lv = ($urandom_range(99) < 8) ? 3'($urandom) : level;
		r = $urandom_range(99);
		if (r < 50)
			delta = '0;
		else if (r < 85)
			delta = 8'($urandom_range(0, 6) - 3);
		else
			delta = 8'($urandom);
		send_tick(delta, lv[BtnSwitch], lv[BtnNext], lv[BtnPrev], $urandom_range(24) == 0);
	endtask

	// A run of random ticks, with one full pause half-way through.
	task automatic run_phase(int count);
		for (int b = 0; b < 3; b++)
			run_left[b] = pick_run(b == BtnSwitch, level[b]);
		for (int i = 0; i < count; i++) begin
			if (i == count / 2)
				drain();
			random_tick();
		end
	endtask

	initial begin
		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: volume driven to both ends, track end with a single track.
		send_tick(8'sh80, 1'b1, 1'b1, 1'b1, 1'b0);
		send_tick(8'sh7F, 1'b1, 1'b1, 1'b1, 1'b0);
		send_tick(8'sh00, 1'b1, 1'b1, 1'b1, 1'b1);

		// No debounce, zero long-press time, zero track count.
		configure(14'd0, 14'd0, 14'd5, 14'd20, 14'd15, 14'd0, 1'b1);
		send_tick(8'sh01, 1'b1, 1'b1, 1'b1, 1'b0);
		send_tick(8'sh00, 1'b0, 1'b1, 1'b1, 1'b0);
		send_tick(8'sh00, 1'b0, 1'b1, 1'b1, 1'b0);
		send_tick(8'sh00, 1'b1, 1'b1, 1'b1, 1'b0);
		send_tick(8'sh00, 1'b1, 1'b1, 1'b1, 1'b0);
		// Next, previous and track end together.
		send_tick(8'sh00, 1'b1, 1'b0, 1'b0, 1'b1);
		send_tick(8'sh00, 1'b1, 1'b0, 1'b0, 1'b1);
		send_tick(8'sh00, 1'b1, 1'b1, 1'b1, 1'b0);
		send_tick(8'sh00, 1'b1, 1'b1, 1'b1, 1'b0);

		// Inverted volume bounds, a short press that pauses, previous wrapping to the top.
		configure(14'd0, 14'd2, 14'd25, 14'd10, 14'd0, 14'd255, 1'b0);
		send_tick(-8'sd1, 1'b1, 1'b1, 1'b1, 1'b0);
		send_tick(8'sh00, 1'b0, 1'b1, 1'b1, 1'b0);
		send_tick(8'sh00, 1'b0, 1'b1, 1'b1, 1'b0);
		send_tick(8'sh00, 1'b1, 1'b1, 1'b1, 1'b0);
		send_tick(8'sh00, 1'b1, 1'b1, 1'b1, 1'b0);
		send_tick(8'sh00, 1'b1, 1'b1, 1'b0, 1'b0);
		send_tick(8'sh00, 1'b1, 1'b1, 1'b0, 1'b0);

		// Count lowered below the current track: previous lands on the count.
		configure(14'd0, 14'd2, 14'd25, 14'd10, 14'd31, 14'd4, 1'b0);
		send_tick(8'sh00, 1'b1, 1'b1, 1'b1, 1'b0);
		send_tick(8'sh00, 1'b1, 1'b1, 1'b0, 1'b0);
		send_tick(8'sh00, 1'b1, 1'b1, 1'b0, 1'b0);

		// Random phases over a range of settings; the first runs with no idling at all.
		calm = 1'b1;
		configure(14'd0, 14'd0, 14'd0, 14'd30, 14'($urandom), 14'd5, 1'b0);
		run_phase(150);
		calm = 1'b0;
		configure(14'd1, 14'd3, 14'd0, 14'd31, 14'($urandom), 14'd0, 1'b0);
		run_phase(150);
		// The result side holds off for a long stretch while ticks keep coming.
		configure(14'd2, 14'd8, 14'd10, 14'd20, 14'($urandom), 14'd255, 1'b0);
		hold_off_req = 1'b1;
		run_phase(150);
		configure(14'd3, 14'd1, 14'd25, 14'd5, 14'($urandom), 14'd2, 1'b0);
		run_phase(150);
		configure(14'd1000, 14'd10000, 14'd0, 14'd30, 14'($urandom), 14'd1, 1'b0);
		run_phase(40);
		configure(14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF, 1'b0);
		run_phase(30);
		for (int p = 0; p < 7; p++) begin
			configure(14'($urandom_range(0, 5)), 14'($urandom_range(0, 25)),
				14'($urandom_range(0, 12)), 14'($urandom_range(14, 31)), 14'($urandom),
				($urandom_range(0, 4) == 0) ? 14'($urandom) : 14'($urandom_range(1, 8)),
				1'b0);
			run_phase(120);
		end

		drain();
		repeat (TailCycles) @(posedge clk);
		$display("tb_top: %0d ticks sent under %0d register settings, %0d results checked",
			ticks_sent, settings_used, checked);
		$display("tb_top: debounce, short and long presses, volume clamping and track wrap, %s",
			"with stalls on both sides");
		if (mismatches == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
